// ===== src/fp25_pkg.sv =====
// ----------------------------------------------------------------------------
// fp25_pkg
// Shared types, widths and the exponentiation program for the 2^252-3 power.
// ----------------------------------------------------------------------------
package fp25_pkg;

  localparam int ELEM_W   = 256;
  localparam int WORD_W   = 64;
  localparam int TOP_W    = 63;
  localparam int LIMB_W   = 32;
  localparam int PROG_LEN = 22;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [1:0]        reg_idx_t;
  typedef logic [4:0]        pc_t;
  typedef logic [6:0]        rep_t;

  localparam reg_idx_t REG_X  = 2'd0;
  localparam reg_idx_t REG_E0 = 2'd1;
  localparam reg_idx_t REG_E1 = 2'd2;
  localparam reg_idx_t REG_E2 = 2'd3;

  // dst <= a*b, then (n-1) more squarings of dst in place
  typedef struct packed {
    reg_idx_t dst;
    reg_idx_t a;
    reg_idx_t b;
    rep_t     n;
  } op_t;

  localparam pc_t LAST_PC = pc_t'(PROG_LEN - 1);

  function automatic op_t prog_op(input pc_t pc);
    op_t o;
    unique case (pc)
      5'd0:    o = '{REG_E0, REG_X,  REG_X,  7'd1};
      5'd1:    o = '{REG_E1, REG_E0, REG_E0, 7'd2};
      5'd2:    o = '{REG_E1, REG_X,  REG_E1, 7'd1};
      5'd3:    o = '{REG_E0, REG_E0, REG_E1, 7'd1};
      5'd4:    o = '{REG_E0, REG_E0, REG_E0, 7'd1};
      5'd5:    o = '{REG_E0, REG_E1, REG_E0, 7'd1};
      5'd6:    o = '{REG_E1, REG_E0, REG_E0, 7'd5};
      5'd7:    o = '{REG_E0, REG_E1, REG_E0, 7'd1};
      5'd8:    o = '{REG_E1, REG_E0, REG_E0, 7'd10};
      5'd9:    o = '{REG_E1, REG_E1, REG_E0, 7'd1};
      5'd10:   o = '{REG_E2, REG_E1, REG_E1, 7'd20};
      5'd11:   o = '{REG_E1, REG_E2, REG_E1, 7'd1};
      5'd12:   o = '{REG_E1, REG_E1, REG_E1, 7'd10};
      5'd13:   o = '{REG_E0, REG_E1, REG_E0, 7'd1};
      5'd14:   o = '{REG_E1, REG_E0, REG_E0, 7'd50};
      5'd15:   o = '{REG_E1, REG_E1, REG_E0, 7'd1};
      5'd16:   o = '{REG_E2, REG_E1, REG_E1, 7'd100};
      5'd17:   o = '{REG_E1, REG_E2, REG_E1, 7'd1};
      5'd18:   o = '{REG_E1, REG_E1, REG_E1, 7'd50};
      5'd19:   o = '{REG_E0, REG_E1, REG_E0, 7'd1};
      5'd20:   o = '{REG_E0, REG_E0, REG_E0, 7'd2};
      5'd21:   o = '{REG_E0, REG_E0, REG_X,  7'd1};
      default: o = '{REG_E0, REG_E0, REG_X,  7'd1};
    endcase
    return o;
  endfunction

endpackage

// ===== src/fp25_mul.sv =====
// ----------------------------------------------------------------------------
// fp25_mul
// Product of two 256-bit values mod 2^255-19, result below 2^256, on one
// 32x32 multiplier (column scan), then a limb-serial fold of the high half.
// ----------------------------------------------------------------------------
module fp25_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  fp25_pkg::elem_t a,
  input  fp25_pkg::elem_t b,
  output logic            done,
  output fp25_pkg::elem_t product
);
  import fp25_pkg::*;

  typedef enum logic [2:0] {M_IDLE, M_MUL, M_RED, M_FOLD1, M_FOLD2} mstate_t;

  mstate_t      state;
  logic [3:0]   k;
  logic [2:0]   i;
  logic         iss;
  logic         p_vld;
  logic         p_last;
  logic         p_fin;
  logic [63:0]  prod_q;
  logic [71:0]  acc;
  logic [511:0] r;
  logic [2:0]   cnt;
  logic [6:0]   c;
  elem_t        v;

  logic [2:0]   j;
  logic [2:0]   hi_i;
  logic [3:0]   k_nx;
  logic [2:0]   lo_nx;
  logic [31:0]  a_limb;
  logic [31:0]  b_limb;
  logic [71:0]  acc_sum;
  logic [38:0]  red_t;
  logic [256:0] fold_sum;
  logic         is_last;

  always_comb begin
    j        = 3'(k - {1'b0, i});
    hi_i     = (k < 4'd7) ? k[2:0] : 3'd7;
    k_nx     = k + 4'd1;
    lo_nx    = (k_nx > 4'd7) ? 3'(k_nx - 4'd7) : 3'd0;
    a_limb   = a[LIMB_W*i +: LIMB_W];
    b_limb   = b[LIMB_W*j +: LIMB_W];
    is_last  = (i == hi_i);
    acc_sum  = acc + {8'd0, prod_q};
    red_t    = {7'd0, r[31:0]} + 39'(r[287:256]) * 39'd38 + {32'd0, c};
    fold_sum = {1'b0, v} + 257'(13'({6'd0, c}) * 13'd38);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= M_IDLE;
      iss   <= 1'b0;
      p_vld <= 1'b0;
    end else begin
      p_vld  <= iss;
      p_last <= is_last;
      p_fin  <= is_last && (k == 4'd14);
      prod_q <= a_limb * b_limb;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            k     <= '0;
            i     <= '0;
            iss   <= 1'b1;
            acc   <= '0;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          if (iss) begin
            if (is_last) begin
              if (k == 4'd14) iss <= 1'b0;
              else begin
                k <= k_nx;
                i <= lo_nx;
              end
            end else begin
              i <= i + 3'd1;
            end
          end
          if (p_vld) begin
            if (p_fin) begin
              r     <= {acc_sum[63:0], r[511:64]};
              cnt   <= '0;
              c     <= '0;
              state <= M_RED;
            end else if (p_last) begin
              r   <= {acc_sum[31:0], r[511:32]};
              acc <= acc_sum >> LIMB_W;
            end else begin
              acc <= acc_sum;
            end
          end
        end
        M_RED: begin
          // low half plus 38 times high half, one limb per cycle
          v   <= {red_t[31:0], v[255:32]};
          c   <= red_t[38:32];
          r   <= {32'd0, r[511:288], 32'd0, r[255:32]};
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) state <= M_FOLD1;
        end
        M_FOLD1: begin
          v     <= fold_sum[255:0];
          c     <= {6'd0, fold_sum[256]};
          state <= M_FOLD2;
        end
        M_FOLD2: begin
          product <= fold_sum[255:0];
          done    <= 1'b1;
          state   <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pvld_in_mul: assert property (@(posedge clk) disable iff (rst)
    p_vld |-> state == M_MUL) else $error("product beat outside multiply phase");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == M_IDLE) else $error("start while busy");
`endif

endmodule

// ===== src/field_pow_2_252_minus_3.sv =====
// ----------------------------------------------------------------------------
// field_pow_2_252_minus_3
// z^(2^252-3) mod 2^255-19, canonical result, via a 22-step addition chain.
// ----------------------------------------------------------------------------
// Operation: 262 modular products, each of 64 passes of the single 32x32
//   multiplier plus an 8-limb fold; each chain step reads its operands in
//   S_RDA, S_RDB and S_CAPB, and the result is reduced in S_CAN1 and S_CAN2.
// Flow: one item at a time; the next input beat is taken only once the
//   result beat for the last one has been issued.
// Reset: synchronous; clears the sequencer and output valid, no memory clear.
module field_pow_2_252_minus_3 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] value_word0,
  input  logic [63:0] value_word1,
  input  logic [63:0] value_word2,
  input  logic [62:0] value_word3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_word0,
  output logic [63:0] result_word1,
  output logic [63:0] result_word2,
  output logic [62:0] result_word3
);
  import fp25_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RDA, S_RDB, S_CAPB, S_MUL, S_CAN1, S_CAN2} state_t;

  state_t   state;
  pc_t      pc;
  rep_t     rep;
  elem_t    opa;
  elem_t    opb;
  elem_t    v;
  logic     mul_start;
  logic     mul_done;
  elem_t    mul_prod;

  elem_t    mem [4];
  elem_t    rd_data;
  reg_idx_t rd_addr;
  logic     wr_en;
  reg_idx_t wr_addr;
  elem_t    wr_data;

  op_t      op;
  logic     accept;
  elem_t    can_x;
  elem_t    can_s;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    op      = prog_op(pc);
    rd_addr = (state == S_RDB) ? op.b : op.a;
    wr_en   = accept || mul_done;
    wr_addr = accept ? REG_X : op.dst;
    wr_data = accept ? {1'b0, value_word3, value_word2, value_word1, value_word0}
                     : mul_prod;
    can_x   = {1'b0, v[254:0]} + {251'd0, v[255], 1'b0, 1'b0, v[255], v[255]};
    can_s   = v + 256'd19;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  fp25_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (opa),
    .b       (opb),
    .done    (mul_done),
    .product (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_start <= 1'b0;
      out_valid <= 1'b0;
      pc        <= '0;
    end else begin
      mul_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pc    <= '0;
            state <= S_RDA;
          end
        end
        S_RDA: begin
          rep   <= op.n;
          state <= S_RDB;
        end
        S_RDB: begin
          opa   <= rd_data;
          state <= S_CAPB;
        end
        S_CAPB: begin
          opb       <= rd_data;
          mul_start <= 1'b1;
          state     <= S_MUL;
        end
        S_MUL: begin
          if (mul_done) begin
            if (rep > 7'd1) begin
              // in-place squaring runs straight off the product
              rep       <= rep - 7'd1;
              opa       <= mul_prod;
              opb       <= mul_prod;
              mul_start <= 1'b1;
            end else if (pc == LAST_PC) begin
              v     <= mul_prod;
              state <= S_CAN1;
            end else begin
              pc    <= pc + 5'd1;
              state <= S_RDA;
            end
          end
        end
        S_CAN1: begin
          // fold bit 255 as 19, value now below 2^255+19
          v     <= can_x;
          state <= S_CAN2;
        end
        S_CAN2: begin
          if (!out_valid || out_ready) begin
            {result_word3, result_word2, result_word1, result_word0} <=
              can_s[255] ? can_s[254:0] : v[254:0];
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MUL) else $error("product returned outside multiply state");
  a_out_from_can: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_CAN2)) else $error("result beat without reduction");
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= LAST_PC) else $error("program counter past chain end");
  a_rep_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> rep != 7'd0) else $error("zero repeat count in multiply");
`endif

endmodule
